// ===== rtl/pro_pkg.sv =====
package pro_pkg;

  // frame store geometry
  localparam int STORE_BYTES = 262144;
  localparam int ADDR_W      = $clog2(STORE_BYTES);

  // signed width that holds every computed byte address before range check
  localparam int SA_W = 34;

  // configuration port
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_RDATA,
    S_ADDR,
    S_RMW,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    ST_PLOTTED = 2'd0,
    ST_CLIPPED = 2'd1,
    ST_DROPPED = 2'd2,
    ST_READ    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    FMT_PLANAR16 = 3'd0,
    FMT_BYTE     = 3'd1,
    FMT_16BIT    = 3'd2,
    FMT_24BIT    = 3'd3,
    FMT_32BIT    = 3'd4
  } fmt_t;

  typedef enum logic [1:0] {
    ROP_REPLACE = 2'd0,
    ROP_AND     = 2'd1,
    ROP_OR      = 2'd2,
    ROP_XOR     = 2'd3
  } rop_t;

  typedef enum logic [2:0] {
    REG_PIXEL_FORMAT = 3'd0,
    REG_RASTER_OP    = 3'd1,
    REG_LINE_BYTES   = 3'd2,
    REG_PLANE_BYTES  = 3'd3,
    REG_CLIP_LEFT    = 3'd4,
    REG_CLIP_RIGHT   = 3'd5,
    REG_CLIP_TOP     = 3'd6,
    REG_CLIP_BOTTOM  = 3'd7
  } reg_idx_t;

  localparam logic [7:0] PLANAR_MASK0 = 8'h80;

endpackage

// ===== rtl/pro_in_if.sv =====
interface pro_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic [31:0]        pixel_value;
  logic [17:0]        read_address;

  modport source (
    output valid, cmd, pos_x, pos_y, pixel_value, read_address,
    input  ready
  );
  modport sink (
    input  valid, cmd, pos_x, pos_y, pixel_value, read_address,
    output ready
  );
endinterface

// ===== rtl/pro_out_if.sv =====
interface pro_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] read_data;

  modport source (
    output valid, status, read_data,
    input  ready
  );
  modport sink (
    input  valid, status, read_data,
    output ready
  );
endinterface

// ===== rtl/pixel_raster_op_writer.sv =====
// Pixel writer with raster operation over a byte-wide frame store of STORE_BYTES bytes.
// Each accepted word is either a plot (clip, address, then read-modify-write of one
// to four bytes, or four plane bytes in planar mode) or a one-byte read, and gives
// exactly one result word. One word is worked on at a time: a read or a clipped,
// dropped or rejected plot goes straight to its result, while a plot that is written
// does a read-modify-write of each byte touched (1 to 4), one byte after another, since
// the simple dual-port byte store does one read and one write per cycle; the byte
// read-modify-writes overlap. The address path has one signed multiplier (y times
// line_bytes) with a register after it. After reset the store is cleared to zero one
// byte per cycle, during which no word is accepted; configuration writes are taken at
// any time and should only be made while the block is idle.
module pixel_raster_op_writer (
  input  logic                       clk,
  input  logic                       rst,
  pro_in_if.sink                     req,
  pro_out_if.source                  rsp,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pro_pkg::PADDR_W-1:0] paddr,
  input  logic [pro_pkg::PDATA_W-1:0] pwdata,
  output logic [pro_pkg::PDATA_W-1:0] prdata,
  output logic                       pready
);
  import pro_pkg::*;

  // configuration
  logic [2:0]         pixel_format;
  logic [1:0]         raster_op;
  logic [13:0]        line_bytes;
  logic [16:0]        plane_bytes;
  logic signed [15:0] clip_left;
  logic signed [15:0] clip_right;
  logic signed [15:0] clip_top;
  logic signed [15:0] clip_bottom;

  logic     cfg_we;
  reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= FMT_BYTE;
      raster_op    <= ROP_REPLACE;
      line_bytes   <= 14'd640;
      plane_bytes  <= 17'd65536;
      clip_left    <= 16'sd0;
      clip_right   <= 16'sd639;
      clip_top     <= 16'sd0;
      clip_bottom  <= 16'sd479;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_PIXEL_FORMAT: pixel_format <= pwdata[2:0];
        REG_RASTER_OP:    raster_op    <= pwdata[1:0];
        REG_LINE_BYTES:   line_bytes   <= pwdata[13:0];
        REG_PLANE_BYTES:  plane_bytes  <= pwdata[16:0];
        REG_CLIP_LEFT:    clip_left    <= pwdata[15:0];
        REG_CLIP_RIGHT:   clip_right   <= pwdata[15:0];
        REG_CLIP_TOP:     clip_top     <= pwdata[15:0];
        REG_CLIP_BOTTOM:  clip_bottom  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_PIXEL_FORMAT: prdata = {29'd0, pixel_format};
      REG_RASTER_OP:    prdata = {30'd0, raster_op};
      REG_LINE_BYTES:   prdata = {18'd0, line_bytes};
      REG_PLANE_BYTES:  prdata = {15'd0, plane_bytes};
      REG_CLIP_LEFT:    prdata = {{16{clip_left[15]}}, clip_left};
      REG_CLIP_RIGHT:   prdata = {{16{clip_right[15]}}, clip_right};
      REG_CLIP_TOP:     prdata = {{16{clip_top[15]}}, clip_top};
      REG_CLIP_BOTTOM:  prdata = {{16{clip_bottom[15]}}, clip_bottom};
      default:          prdata = '0;
    endcase
  end

  // frame store
  logic [7:0]        mem [STORE_BYTES];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [7:0]        mem_q;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= mem[mem_raddr];
  end

  // control and working registers
  state_t             state;
  state_t             state_next;
  logic [ADDR_W-1:0]  clr_cnt;
  logic               cmd_r;
  logic signed [15:0] x_r;
  logic signed [15:0] y_r;
  logic [31:0]        colour_r;
  logic [17:0]        raddr_r;
  logic signed [30:0] prod_r;
  logic               clip_r;
  logic               planar_r;
  logic [2:0]         nbytes;
  logic [2:0]         issued;
  logic [ADDR_W-1:0]  cur_addr;
  logic [ADDR_W-1:0]  step_r;
  logic               pend;
  logic [ADDR_W-1:0]  pend_addr;
  logic [1:0]         pend_k;
  logic               fwd_r;
  logic [7:0]         fwd_data;
  logic [1:0]         res_status;
  logic [7:0]         res_data;
  logic               out_valid;
  logic [1:0]         out_status;
  logic [7:0]         out_data;

  // address math for the plot
  logic signed [SA_W-1:0] xs;
  logic signed [SA_W-1:0] prod_s;
  logic signed [SA_W-1:0] pb_s;
  logic signed [SA_W-1:0] pl_base;
  logic signed [SA_W-1:0] first;
  logic signed [SA_W-1:0] last;
  logic [2:0]             fmt_bytes;
  logic                   fmt_ok;
  logic                   span_ok;
  logic [SA_W-1:0]        raddr_ext;
  logic                   rd_ok;
  logic                   issue;
  logic [7:0]             old_byte;
  logic [7:0]             new_byte;
  logic                   out_load;

  assign xs      = {{(SA_W-16){x_r[15]}}, x_r};
  assign prod_s  = {{(SA_W-31){prod_r[30]}}, prod_r};
  assign pb_s    = {{(SA_W-17){1'b0}}, plane_bytes};
  assign pl_base = (prod_s >>> 2) + (xs >>> 3);

  always_comb begin
    fmt_ok    = 1'b1;
    fmt_bytes = 3'd1;
    first     = prod_s + xs;
    last      = first;
    case (fmt_t'(pixel_format))
      FMT_PLANAR16: begin
        fmt_bytes = 3'd4;
        first     = pl_base;
        last      = pl_base + pb_s + (pb_s <<< 1);
      end
      FMT_BYTE: begin
        fmt_bytes = 3'd1;
        first     = prod_s + xs;
        last      = first;
      end
      FMT_16BIT: begin
        fmt_bytes = 3'd2;
        first     = prod_s + (xs <<< 1);
        last      = prod_s + (xs <<< 1) + SA_W'(1);
      end
      FMT_24BIT: begin
        fmt_bytes = 3'd3;
        first     = prod_s + xs + (xs <<< 1);
        last      = prod_s + xs + (xs <<< 1) + SA_W'(2);
      end
      FMT_32BIT: begin
        fmt_bytes = 3'd4;
        first     = prod_s + (xs <<< 2);
        last      = prod_s + (xs <<< 2) + SA_W'(3);
      end
      default: fmt_ok = 1'b0;
    endcase
  end

  assign span_ok   = !first[SA_W-1] && (last < $signed(SA_W'(STORE_BYTES)));
  assign raddr_ext = {{(SA_W-18){1'b0}}, raddr_r};
  assign rd_ok     = raddr_ext < SA_W'(STORE_BYTES);
  assign issue     = (issued != nbytes);

  function automatic logic [7:0] modify(input logic planar, input logic [1:0] rop,
                                        input logic [7:0] old, input logic [31:0] colour,
                                        input logic [1:0] k, input logic [2:0] xlow);
    logic [7:0] mask;
    logic [7:0] val;
    logic       bit_k;
    logic [7:0] res;
    mask  = PLANAR_MASK0 >> xlow;
    val   = colour[8*k +: 8];
    bit_k = colour[k];
    res   = old;
    if (planar) begin
      case (rop_t'(rop))
        ROP_REPLACE: res = bit_k ? (old | mask) : (old & ~mask);
        ROP_AND:     res = bit_k ? old : (old & ~mask);
        ROP_OR:      res = bit_k ? (old | mask) : old;
        ROP_XOR:     res = bit_k ? (old ^ mask) : old;
        default:     res = old;
      endcase
    end else begin
      case (rop_t'(rop))
        ROP_REPLACE: res = val;
        ROP_AND:     res = old & val;
        ROP_OR:      res = old | val;
        ROP_XOR:     res = old ^ val;
        default:     res = old;
      endcase
    end
    return res;
  endfunction

  // a read issued while the previous byte of the same address was written sees old data
  assign old_byte = fwd_r ? fwd_data : mem_q;
  assign new_byte = modify(planar_r, raster_op, old_byte, colour_r, pend_k, x_r[2:0]);

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = pend_addr;
    mem_wdata  = new_byte;
    mem_raddr  = cur_addr;
    out_load   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = '0;
        if (clr_cnt == ADDR_W'(STORE_BYTES - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) state_next = S_MUL;
      end
      S_MUL: begin
        mem_raddr  = raddr_ext[ADDR_W-1:0];
        state_next = cmd_r ? S_RDATA : S_ADDR;
      end
      S_RDATA: state_next = S_DONE;
      S_ADDR: begin
        if (clip_r || !fmt_ok || !span_ok) state_next = S_DONE;
        else state_next = S_RMW;
      end
      S_RMW: begin
        mem_we = pend;
        if (!issue) state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      pend    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (state == S_RMW) pend <= issue;
      else pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cmd_r    <= req.cmd;
        x_r      <= req.pos_x;
        y_r      <= req.pos_y;
        colour_r <= req.pixel_value;
        raddr_r  <= req.read_address;
      end
      S_MUL: begin
        prod_r <= $signed({{15{y_r[15]}}, y_r}) * $signed({17'd0, line_bytes});
        clip_r <= (x_r < clip_left) || (x_r > clip_right) ||
                  (y_r < clip_top) || (y_r > clip_bottom);
      end
      S_RDATA: begin
        res_status <= ST_READ;
        res_data   <= rd_ok ? mem_q : 8'd0;
      end
      S_ADDR: begin
        res_data   <= 8'd0;
        res_status <= clip_r ? ST_CLIPPED : ((fmt_ok && span_ok) ? ST_PLOTTED : ST_DROPPED);
        planar_r   <= (fmt_t'(pixel_format) == FMT_PLANAR16);
        nbytes     <= fmt_bytes;
        issued     <= 3'd0;
        cur_addr   <= first[ADDR_W-1:0];
        step_r     <= (fmt_t'(pixel_format) == FMT_PLANAR16) ? pb_s[ADDR_W-1:0]
                                                              : ADDR_W'(1);
      end
      S_RMW: begin
        if (issue) begin
          cur_addr  <= cur_addr + step_r;
          issued    <= issued + 3'd1;
          pend_addr <= cur_addr;
          pend_k    <= issued[1:0];
          fwd_r     <= pend && (pend_addr == cur_addr);
          fwd_data  <= new_byte;
        end
      end
      default: ;
    endcase
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= res_status;
      out_data   <= res_data;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.read_data = out_data;

endmodule

// ===== dv/pixel_raster_op_writer_tb.sv =====
`timescale 1ns / 100ps

module pixel_raster_op_writer_tb;
  import pro_pkg::*;

  // no word, result or register write for this long ends the run; covers the clear after reset
  localparam int IDLE_LIMIT  = 1000000;
  localparam int HOLD_CYCLES = 300;

  // format codes that the block does not support
  localparam logic [2:0] FMT_UNUSED_LO = 3'd5;
  localparam logic [2:0] FMT_UNUSED_HI = 3'd7;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

  typedef struct {
    logic               cmd;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [31:0]        pixel_value;
    logic [17:0]        read_address;
  } pixel_word_t;

  typedef struct {
    status_t    status;
    logic [7:0] read_data;
  } word_result_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  pro_in_if  req_if ();
  pro_out_if rsp_if ();

  pixel_raster_op_writer u_top (
    .clk     (clk),
    .rst     (rst),
    .req     (req_if),
    .rsp     (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the frame store and the registers
  bit [7:0]    shadow_fb [STORE_BYTES];
  logic [2:0]  cfg_fmt;
  rop_t        cfg_rop;
  int          cfg_line;
  int          cfg_plane;
  int          clip_l;
  int          clip_r;
  int          clip_t;
  int          clip_b;

  word_result_t pending_results [$];
  word_result_t head_result;
  int unsigned  recent_addrs [$];
  int           error_count;

  // stimulus shaping
  int       box_x0;
  int       box_x1;
  int       box_y0;
  int       box_y1;
  bit       tx_gaps;
  int       burst_left;
  rx_mode_t rx_mode;
  bit       hold_req;
  int       hold_left;
  int       rx_tick;
  int       idle_cycles;

  function automatic bit in_store(longint a);
    return a >= 0 && a < STORE_BYTES;
  endfunction

  function automatic void note_write(longint a);
    recent_addrs.push_back(int'(a));
    if (recent_addrs.size() > 64) void'(recent_addrs.pop_front());
  endfunction

  function automatic logic [7:0] combine_byte(logic [7:0] old, logic [7:0] val);
    case (cfg_rop)
      ROP_REPLACE: return val;
      ROP_AND:     return old & val;
      ROP_OR:      return old | val;
      default:     return old ^ val;
    endcase
  endfunction

  function automatic status_t draw_planar(int x, int y, logic [31:0] colour);
    longint     base;
    longint     addr [4];
    logic [7:0] mask;
    logic [7:0] cur;
    int         i;
    // arithmetic shifts give floor division for negative offsets
    base = ((longint'(y) * cfg_line) >>> 2) + (longint'(x) >>> 3);
    mask = PLANAR_MASK0 >> x[2:0];
    for (i = 0; i < 4; i++) begin
      addr[i] = longint'(i) * cfg_plane + base;
      if (!in_store(addr[i])) return ST_DROPPED;
    end
    for (i = 0; i < 4; i++) begin
      cur = shadow_fb[addr[i]];
      case (cfg_rop)
        ROP_REPLACE: cur = colour[i] ? (cur | mask) : (cur & ~mask);
        ROP_AND:     if (!colour[i]) cur = cur & ~mask;
        ROP_OR:      if (colour[i]) cur = cur | mask;
        default:     if (colour[i]) cur = cur ^ mask;
      endcase
      shadow_fb[addr[i]] = cur;
      note_write(addr[i]);
    end
    return ST_PLOTTED;
  endfunction

  function automatic status_t draw_packed(int x, int y, logic [31:0] colour, int nb);
    longint a;
    int     k;
    a = longint'(y) * cfg_line + longint'(x) * nb;
    if (!in_store(a) || !in_store(a + nb - 1)) return ST_DROPPED;
    for (k = 0; k < nb; k++) begin
      shadow_fb[a + k] = combine_byte(shadow_fb[a + k], colour[8*k +: 8]);
      note_write(a + k);
    end
    return ST_PLOTTED;
  endfunction

  // applies one word to the shadow store and returns the result it must give
  function automatic word_result_t render_word(pixel_word_t w);
    word_result_t r;
    int           x;
    int           y;
    r.read_data = '0;
    if (w.cmd) begin
      r.status = ST_READ;
      if (in_store(w.read_address)) r.read_data = shadow_fb[w.read_address];
      return r;
    end
    x = w.pos_x;
    y = w.pos_y;
    if (x < clip_l || x > clip_r || y < clip_t || y > clip_b) begin
      r.status = ST_CLIPPED;
    end else begin
      case (cfg_fmt)
        FMT_PLANAR16: r.status = draw_planar(x, y, w.pixel_value);
        FMT_BYTE:     r.status = draw_packed(x, y, w.pixel_value, 1);
        FMT_16BIT:    r.status = draw_packed(x, y, w.pixel_value, 2);
        FMT_24BIT:    r.status = draw_packed(x, y, w.pixel_value, 3);
        FMT_32BIT:    r.status = draw_packed(x, y, w.pixel_value, 4);
        default:      r.status = ST_DROPPED;
      endcase
    end
    return r;
  endfunction

  function automatic pixel_word_t make_word(logic cmd, int x, int y, logic [31:0] pv,
                                            int unsigned ra);
    pixel_word_t w;
    w.cmd          = cmd;
    w.pos_x        = 16'(x);
    w.pos_y        = 16'(y);
    w.pixel_value  = pv;
    w.read_address = 18'(ra);
    return w;
  endfunction

  function automatic logic signed [15:0] pick_coord(int lo, int hi);
    if (lo < -32768) lo = -32768;
    if (hi > 32767) hi = 32767;
    if (hi < lo) hi = lo;
    return 16'(lo + int'($urandom_range(0, hi - lo)));
  endfunction

  function automatic int rand_s16();
    logic signed [15:0] v;
    v = 16'($urandom);
    return v;
  endfunction

  function automatic pixel_word_t random_word();
    pixel_word_t w;
    w.cmd          = 1'b0;
    w.pos_x        = 16'($urandom);
    w.pos_y        = 16'($urandom);
    w.pixel_value  = $urandom;
    w.read_address = 18'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      w.cmd = 1'b1;
      // mostly read back bytes that were drawn lately
      if (recent_addrs.size() > 0 && $urandom_range(0, 2) != 0)
        w.read_address = 18'(recent_addrs[$urandom_range(0, recent_addrs.size() - 1)]);
    end else if ($urandom_range(0, 4) != 0) begin
      w.pos_x = pick_coord(box_x0 - 2, box_x1 + 2);
      w.pos_y = pick_coord(box_y0 - 2, box_y1 + 2);
    end
    return w;
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    logic signed [15:0] s16;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    s16 = value[15:0];
    case (idx)
      REG_PIXEL_FORMAT: cfg_fmt = value[2:0];
      REG_RASTER_OP:    cfg_rop = rop_t'(value[1:0]);
      REG_LINE_BYTES:   cfg_line = value[13:0];
      REG_PLANE_BYTES:  cfg_plane = value[16:0];
      REG_CLIP_LEFT:    clip_l = s16;
      REG_CLIP_RIGHT:   clip_r = s16;
      REG_CLIP_TOP:     clip_t = s16;
      default:          clip_b = s16;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic apply_config(logic [2:0] fmt, rop_t rop, int line, int plane,
                              int l, int r, int t, int b);
    wait_idle();
    write_reg(REG_PIXEL_FORMAT, 32'(fmt));
    write_reg(REG_RASTER_OP, 32'(rop));
    write_reg(REG_LINE_BYTES, 32'(line));
    write_reg(REG_PLANE_BYTES, 32'(plane));
    write_reg(REG_CLIP_LEFT, 32'(l));
    write_reg(REG_CLIP_RIGHT, 32'(r));
    write_reg(REG_CLIP_TOP, 32'(t));
    write_reg(REG_CLIP_BOTTOM, 32'(b));
  endtask

  task automatic set_box(int x0, int x1, int y0, int y1);
    box_x0 = x0;
    box_x1 = x1;
    box_y0 = y0;
    box_y1 = y1;
  endtask

  task automatic send_word(pixel_word_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (tx_gaps) begin
        gap = $urandom_range(1, 6);
        @(negedge clk);
        req_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    req_if.valid        <= 1'b1;
    req_if.cmd          <= w.cmd;
    req_if.pos_x        <= w.pos_x;
    req_if.pos_y        <= w.pos_y;
    req_if.pixel_value  <= w.pixel_value;
    req_if.read_address <= w.read_address;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    pending_results.push_back(render_word(w));
  endtask

  task automatic run_items(int n);
    repeat (n) send_word(random_word());
  endtask

  task automatic randomize_config();
    logic [2:0] fmt;
    int         line;
    int         plane;
    int         l;
    int         r;
    int         t;
    int         b;
    int         sel;
    fmt = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(FMT_UNUSED_LO, FMT_UNUSED_HI))
                                      : 3'($urandom_range(FMT_PLANAR16, FMT_32BIT));
    sel = $urandom_range(0, 9);
    if (sel == 0) line = 0;
    else if (sel == 1) line = 16383;
    else if (sel < 4) line = $urandom_range(0, 16383);
    else line = $urandom_range(1, 1024);
    sel = $urandom_range(0, 9);
    if (sel == 0) plane = 0;
    else if (sel == 1) plane = 65536;
    else plane = $urandom_range(0, 65536);
    set_box(int'($urandom_range(0, 48)) - 8, 0, int'($urandom_range(0, 20)) - 4, 0);
    box_x1 = box_x0 + int'($urandom_range(0, 320));
    box_y1 = box_y0 + int'($urandom_range(0, 60));
    sel = $urandom_range(0, 19);
    if (sel < 3) begin
      l = -32768; r = 32767; t = -32768; b = 32767;
    end else if (sel < 5) begin
      // may well be inverted, so that everything clips
      l = rand_s16(); r = rand_s16(); t = rand_s16(); b = rand_s16();
    end else begin
      l = box_x0 + int'($urandom_range(0, 3)) - 1;
      r = box_x1 + int'($urandom_range(0, 3)) - 2;
      t = box_y0 + int'($urandom_range(0, 3)) - 1;
      b = box_y1 + int'($urandom_range(0, 3)) - 2;
    end
    apply_config(fmt, rop_t'($urandom_range(0, 3)), line, plane, l, r, t, b);
  endtask

  // reset settings: byte pixels, replace, 640 by 480 clip
  task automatic test_clip_edges();
    send_word(make_word(1'b0, 0, 0, 32'h0000_00A5, 0));
    send_word(make_word(1'b0, 639, 0, 32'h0000_0000, 0));
    send_word(make_word(1'b0, 639, 479, 32'hFFFF_FFFF, 0));
    send_word(make_word(1'b0, 0, 479, 32'h1234_5678, 0));
    send_word(make_word(1'b0, -1, 0, 32'hFFFF_FFFF, 0));
    send_word(make_word(1'b0, 640, 0, 32'hFFFF_FFFF, 0));
    send_word(make_word(1'b0, 0, -1, 32'hFFFF_FFFF, 0));
    send_word(make_word(1'b0, 0, 480, 32'hFFFF_FFFF, 0));
    // a read ignores the clip window and the position
    send_word(make_word(1'b1, -32768, -32768, 32'hFFFF_FFFF, 0));
    send_word(make_word(1'b1, 32767, 32767, 32'h0, STORE_BYTES - 1));
  endtask

  task automatic test_formats_and_ops();
    int unsigned probe [5] = '{4096 + 5, 25, 35, 45, 55};
    int          i;
    apply_config(FMT_BYTE, ROP_REPLACE, 16, 4096, -32768, 32767, -32768, 32767);
    for (i = 0; i < 5; i++) begin
      wait_idle();
      write_reg(REG_PIXEL_FORMAT, 32'(i));
      write_reg(REG_RASTER_OP, 32'(i % 4));
      send_word(make_word(1'b0, 9, 1, 32'hC3A5_5A3C ^ 32'(i), 0));
      send_word(make_word(1'b1, 0, 0, 32'h0, probe[i]));
    end
    wait_idle();
    write_reg(REG_PIXEL_FORMAT, 32'(FMT_UNUSED_LO));
    send_word(make_word(1'b0, 2, 2, 32'hFFFF_FFFF, 0));
    wait_idle();
    write_reg(REG_PIXEL_FORMAT, 32'(FMT_UNUSED_HI));
    send_word(make_word(1'b0, 3, 3, 32'hFFFF_FFFF, 0));
    // extreme positions land outside the store
    wait_idle();
    write_reg(REG_PIXEL_FORMAT, 32'(FMT_BYTE));
    send_word(make_word(1'b0, -32768, 32767, 32'h0, 0));
    send_word(make_word(1'b0, 32767, -32768, 32'hFFFF_FFFF, 0));
  endtask

  task automatic test_config_extremes();
    tx_gaps = 1'b1;
    rx_mode = RX_RANDOM;
    apply_config(FMT_32BIT, ROP_XOR, 16383, 65536, -32768, 32767, -32768, 32767);
    set_box(-4, 40, -2, 4);
    run_items(30);
    apply_config(FMT_PLANAR16, ROP_AND, 0, 0, 0, 100, 0, 10);
    set_box(0, 100, 0, 10);
    run_items(30);
  endtask

  task automatic test_backpressure();
    apply_config(FMT_24BIT, ROP_OR, 320, 65536, 0, 319, 0, 199);
    set_box(0, 319, 0, 30);
    tx_gaps  = 1'b0;
    rx_mode  = RX_RANDOM;
    hold_req = 1'b1;
    run_items(60);
  endtask

  task automatic test_random_mixed();
    repeat (10) begin
      randomize_config();
      tx_gaps = ($urandom_range(0, 2) != 0);
      rx_mode = rx_mode_t'($urandom_range(RX_ALWAYS, RX_PATTERN));
      run_items(100);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing pending: status %0d read_data 0x%02h",
               rsp_if.status, rsp_if.read_data);
        error_count++;
      end else begin
        head_result = pending_results.pop_front();
        if (rsp_if.status !== head_result.status) begin
          $error("status: expected %0d, got %0d", head_result.status, rsp_if.status);
          error_count++;
        end
        if (rsp_if.read_data !== head_result.read_data) begin
          $error("read_data: expected 0x%02h, got 0x%02h", head_result.read_data,
                 rsp_if.read_data);
          error_count++;
        end
      end
    end
  end

  // result receiver: always ready, random or fixed stall pattern, with one long hold on request
  always @(negedge clk) begin
    rx_tick++;
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_if.ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS: rsp_if.ready <= 1'b1;
        RX_RANDOM: rsp_if.ready <= ($urandom_range(0, 3) != 0);
        default:   rsp_if.ready <= ((rx_tick % 11) < 7);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (psel && penable && pwrite && pready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("pixel_raster_op_writer_tb: errors");
      $finish;
    end
  end

  initial begin
    rst                 = 1'b1;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    req_if.valid        = 1'b0;
    req_if.cmd          = 1'b0;
    req_if.pos_x        = '0;
    req_if.pos_y        = '0;
    req_if.pixel_value  = '0;
    req_if.read_address = '0;
    rsp_if.ready        = 1'b0;
    cfg_fmt             = FMT_BYTE;
    cfg_rop             = ROP_REPLACE;
    cfg_line            = 640;
    cfg_plane           = 65536;
    clip_l              = 0;
    clip_r              = 639;
    clip_t              = 0;
    clip_b              = 479;
    error_count         = 0;
    burst_left          = 0;
    tx_gaps             = 1'b0;
    rx_mode             = RX_ALWAYS;
    hold_req            = 1'b0;
    hold_left           = 0;
    rx_tick             = 0;
    idle_cycles         = 0;
    set_box(0, 639, 0, 479);
    repeat (2) @(negedge clk);
    rst = 1'b0;

    test_clip_edges();
    test_formats_and_ops();
    test_config_extremes();
    test_backpressure();
    test_random_mixed();

    wait_idle();
    repeat (8) @(posedge clk);
    if (error_count == 0) $display("pixel_raster_op_writer_tb: clean");
    else $display("pixel_raster_op_writer_tb: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/pro_pkg.sv
rtl/pro_in_if.sv
rtl/pro_out_if.sv
rtl/pixel_raster_op_writer.sv
dv/pixel_raster_op_writer_tb.sv
